// ----- design/gsde_pkg.sv -----
// Shared types, event codes and code tables for the gamepad delta event encoder.
package gsde_pkg;

    // command codes
    localparam logic [2:0] FN_PUBLISH    = 3'd0;
    localparam logic [2:0] FN_RESET      = 3'd1;
    localparam logic [2:0] FN_RESEND     = 3'd2;
    localparam logic [2:0] FN_ACTIVATE   = 3'd3;
    localparam logic [2:0] FN_DEACTIVATE = 3'd4;

    // event types
    localparam logic [2:0] EV_SYN = 3'd0;
    localparam logic [2:0] EV_KEY = 3'd1;
    localparam logic [2:0] EV_ABS = 3'd3;
    localparam logic [2:0] EV_MSC = 3'd4;

    localparam logic [9:0] SCAN_EV_CODE = 10'd4;
    localparam logic [9:0] SYNC_EV_CODE = 10'd0;

    localparam int NUM_BUTTONS = 10;
    localparam int NUM_AXES    = 8;
    localparam int NUM_ITEMS   = NUM_BUTTONS + NUM_AXES;

    localparam logic [9:0] BTN_CODE [NUM_BUTTONS] = '{
        10'h130, 10'h131, 10'h133, 10'h134, 10'h136,
        10'h137, 10'h13a, 10'h13b, 10'h13d, 10'h13e
    };
    localparam logic [9:0] AXIS_CODE [NUM_AXES] = '{
        10'h000, 10'h001, 10'h003, 10'h004, 10'h009, 10'h00a, 10'h010, 10'h011
    };

    typedef struct packed {
        logic [2:0]         func;
        logic [1:0]         slot;
        logic [9:0]         buttons;
        logic signed [16:0] left_x;
        logic signed [16:0] left_y;
        logic signed [16:0] right_x;
        logic signed [16:0] right_y;
        logic signed [9:0]  trig_left;
        logic signed [9:0]  trig_right;
        logic [3:0]         dpad;
    } cmd_t;

    // per-slot record; axes order X, Y, RX, RY, GAS, BRAKE, HAT0X, HAT0Y
    typedef struct packed {
        logic                          active;
        logic [NUM_BUTTONS-1:0]        buttons;
        logic [NUM_AXES-1:0][15:0]     axes;
        logic [31:0]                   seqlock;
        logic [31:0]                   generation;
        logic [31:0]                   resync;
    } rec_t;

    localparam rec_t REC_RESET = '{
        active: 1'b0, buttons: '0, axes: '0,
        seqlock: 32'd0, generation: 32'd1, resync: 32'd0
    };

    // what one run of events needs
    typedef struct packed {
        logic [1:0]                slot;
        logic [NUM_BUTTONS-1:0]    buttons;
        logic [NUM_AXES-1:0][15:0] axes;
        logic [NUM_ITEMS-1:0]      mask;     // buttons low, axes high
        logic [31:0]               seq;
        logic [31:0]               generation;
        logic [31:0]               resync;
    } run_t;

    typedef struct packed {
        logic run;   // emit a run, write back at its end
        logic dea;   // deactivate, write back now
        rec_t rec;
        run_t info;
    } plan_t;

    typedef struct packed {
        logic [2:0]  etype;
        logic [9:0]  code;
        logic [15:0] value;
        logic [7:0]  ring;
        logic [1:0]  slot;
        logic [31:0] seq;
        logic [31:0] generation;
        logic [31:0] resync;
        logic        last;
    } ev_t;

endpackage

// ----- design/gsde_state_mem.sv -----
// Per-slot state memory: synchronous read, one write port, reset value until written.
module gsde_state_mem import gsde_pkg::*; #(
    parameter int             W         = 8,
    parameter int             DEPTH     = 4,
    parameter int             AW        = 2,
    parameter logic [W-1:0]   RESET_VAL = '0
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [W-1:0]  rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [W-1:0]  wr_data
);

    logic [W-1:0]     mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [W-1:0]     rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : RESET_VAL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/gsde_delta.sv -----
// Command decode, clamping, d-pad to hat, change mask and next slot record.
module gsde_delta import gsde_pkg::*; (
    input  cmd_t  cmd,
    input  logic  slot_ok,
    input  rec_t  rec,
    output plan_t plan
);

    function automatic logic [15:0] clamp_stick(input logic signed [16:0] v);
        logic [15:0] r;
        if (v > 17'sd32767) begin
            r = 16'h7fff;
        end else if (v < -17'sd32767) begin
            r = 16'h8001;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic [15:0] clamp_trig(input logic signed [9:0] v);
        logic [15:0] r;
        if (v < 10'sd0) begin
            r = 16'd0;
        end else if (v > 10'sd255) begin
            r = 16'd255;
        end else begin
            r = {8'b0, v[7:0]};
        end
        return r;
    endfunction

    logic [NUM_AXES-1:0][15:0] pub_axes;
    logic [NUM_AXES-1:0][15:0] na;
    logic [NUM_BUTTONS-1:0]    nb;
    logic                      force_all;
    logic                      ok;
    logic                      dea;
    logic [NUM_ITEMS-1:0]      diff;
    logic [NUM_ITEMS-1:0]      mask;
    logic [31:0]               seq_even;

    always_comb begin
        pub_axes[0] = clamp_stick(cmd.left_x);
        pub_axes[1] = clamp_stick(cmd.left_y);
        pub_axes[2] = clamp_stick(cmd.right_x);
        pub_axes[3] = clamp_stick(cmd.right_y);
        pub_axes[4] = clamp_trig(cmd.trig_right);
        pub_axes[5] = clamp_trig(cmd.trig_left);
        // left beats right, up beats down
        pub_axes[6] = cmd.dpad[3] ? 16'hffff : (cmd.dpad[1] ? 16'h0001 : 16'h0000);
        pub_axes[7] = cmd.dpad[0] ? 16'hffff : (cmd.dpad[2] ? 16'h0001 : 16'h0000);
    end

    always_comb begin
        ok        = 1'b0;
        dea       = 1'b0;
        force_all = 1'b1;
        nb        = '0;
        na        = '0;
        unique case (cmd.func)
            FN_PUBLISH: begin
                ok        = slot_ok && rec.active;
                force_all = 1'b0;
                nb        = cmd.buttons;
                na        = pub_axes;
            end
            FN_RESET: begin
                ok = slot_ok && rec.active;
            end
            FN_RESEND: begin
                ok = slot_ok && rec.active;
                nb = rec.buttons;
                na = rec.axes;
            end
            FN_ACTIVATE: begin
                ok = slot_ok && !rec.active;
            end
            FN_DEACTIVATE: begin
                dea = slot_ok && rec.active;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        diff[NUM_BUTTONS-1:0] = nb ^ rec.buttons;
        for (int i = 0; i < NUM_AXES; i++) begin
            diff[NUM_BUTTONS + i] = (na[i] != rec.axes[i]);
        end
        mask     = force_all ? '1 : diff;
        seq_even = rec.seqlock[0] ? rec.seqlock + 32'd1 : rec.seqlock;
    end

    always_comb begin
        plan.run = ok && (|mask);
        plan.dea = dea;

        plan.info.slot       = cmd.slot;
        plan.info.buttons    = nb;
        plan.info.axes       = na;
        plan.info.mask       = mask;
        plan.info.seq        = seq_even + 32'd1;
        plan.info.generation = rec.generation;
        plan.info.resync     = rec.resync + {31'b0, force_all};

        if (dea) begin
            plan.rec.active     = 1'b0;
            plan.rec.buttons    = '0;
            plan.rec.axes       = '0;
            plan.rec.generation = rec.generation + 32'd1;
            plan.rec.resync     = rec.resync + 32'd1;
        end else begin
            plan.rec.active     = 1'b1;
            plan.rec.buttons    = nb;
            plan.rec.axes       = na;
            plan.rec.generation = rec.generation;
            plan.rec.resync     = rec.resync + {31'b0, force_all};
        end
        plan.rec.seqlock = seq_even + 32'd2;
    end

endmodule

// ----- design/gsde_emitter.sv -----
// Sequencer: scans buttons, axes and sync one per cycle unless stalled, into out_reg.
module gsde_emitter import gsde_pkg::*; #(
    parameter int RING_DEPTH = 256,
    parameter int PTR_W      = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  run_t             run,
    input  logic [PTR_W-1:0] ptr_start,
    output logic             done,
    output logic [PTR_W-1:0] ptr_final,
    output logic             ev_valid,
    input  logic             ev_ready,
    output ev_t              ev
);

    localparam int IDX_W = $clog2(NUM_ITEMS + 1);

    logic             busy_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             phase_reg, phase_next;
    logic [PTR_W-1:0] ptr_reg;
    run_t             run_reg;
    logic             out_valid_reg;
    ev_t              out_reg;

    logic             adv;
    logic             emit;
    logic             finish;
    ev_t              cand;
    logic [3:0]       btn_i;
    logic [2:0]       ax_i;

    assign adv   = busy_reg && (!out_valid_reg || ev_ready);
    assign btn_i = idx_reg[3:0];
    assign ax_i  = 3'(idx_reg - IDX_W'(NUM_BUTTONS));

    always_comb begin
        emit       = 1'b0;
        finish     = 1'b0;
        idx_next   = idx_reg + IDX_W'(1);
        phase_next = 1'b0;

        cand.etype      = EV_SYN;
        cand.code       = SYNC_EV_CODE;
        cand.value      = '0;
        cand.ring       = 8'(ptr_reg);
        cand.slot       = run_reg.slot;
        cand.seq        = run_reg.seq;
        cand.generation = run_reg.generation;
        cand.resync     = run_reg.resync;
        cand.last       = 1'b0;

        priority if (idx_reg < IDX_W'(NUM_BUTTONS)) begin
            if (run_reg.mask[idx_reg]) begin
                emit = 1'b1;
                if (phase_reg) begin
                    cand.etype = EV_KEY;
                    cand.code  = BTN_CODE[btn_i];
                    cand.value = {15'b0, run_reg.buttons[btn_i]};
                end else begin
                    // scan word then key word for the same button
                    cand.etype = EV_MSC;
                    cand.code  = SCAN_EV_CODE;
                    cand.value = {6'b0, BTN_CODE[btn_i]};
                    idx_next   = idx_reg;
                    phase_next = 1'b1;
                end
            end
        end else if (idx_reg < IDX_W'(NUM_ITEMS)) begin
            if (run_reg.mask[idx_reg]) begin
                emit       = 1'b1;
                cand.etype = EV_ABS;
                cand.code  = AXIS_CODE[ax_i];
                cand.value = run_reg.axes[ax_i];
            end
        end else begin
            emit      = 1'b1;
            finish    = 1'b1;
            cand.last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (start) begin
                busy_reg  <= 1'b1;
                idx_reg   <= '0;
                phase_reg <= 1'b0;
            end else if (adv) begin
                idx_reg   <= idx_next;
                phase_reg <= phase_next;
                if (finish) begin
                    busy_reg <= 1'b0;
                end
            end
            if (adv && emit) begin
                out_valid_reg <= 1'b1;
            end else if (ev_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            run_reg <= run;
            ptr_reg <= ptr_start;
        end else if (adv && emit) begin
            ptr_reg <= (ptr_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_reg + PTR_W'(1);
        end
        if (adv && emit) begin
            out_reg <= cand;
        end
    end

    assign done      = adv && finish;
    assign ptr_final = ptr_reg;
    assign ev_valid  = out_valid_reg;
    assign ev        = out_reg;

endmodule

// ----- design/gamepad_state_delta_event_encoder.sv -----
// Top level of the gamepad state delta event encoder.
//
// Takes one command word per controller slot and turns a state change into a run of
// input-event words. Commands (s_tuser func: publish, reset to neutral, full resend,
// activate, deactivate) read the slot's record from a synchronous per-slot memory,
// compare the clamped new state with it, and emit for each changed button a scan word
// and a key word, for each changed axis an absolute-axis word, then a sync word with
// m_tlast set. Forced commands send every item. Each word carries the ring position
// (write count modulo RING_DEPTH, low 8 bits), the odd seqlock value of the run, and the
// slot's generation and resync counts. Deactivate clears the slot and emits nothing.
// Flow: one command is in flight at a time. A command that emits nothing goes from
// ST_EVAL back to ST_IDLE, where s_tready returns. A run goes through ST_EVAL, ST_EMIT
// and ST_WB; in ST_EMIT the emitter walks the 10 buttons (two words each when changed),
// 8 axes and the sync word one step per cycle, and back-pressure on m_tready stalls it.
// The record is written back in ST_WB, after the sync word is loaded. Memories come out
// of reset through per-entry valid bits, with no clearing pass.
module gamepad_state_delta_event_encoder import gsde_pkg::*; #(
    parameter int RING_DEPTH = 256,
    parameter int NUM_SLOTS  = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [9:0] button_bits, [26:10] left_x, [43:27] left_y, [60:44] right_x,
    // [77:61] right_y, [87:78] trig_left, [97:88] trig_right, [101:98] dpad_bits
    input  logic [103:0] s_tdata,
    // [2:0] func, [4:3] slot
    input  logic [4:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [9:0] ev_code, [25:10] ev_value, [33:26] ring_index, [65:34] seqlock_count,
    // [97:66] generation_count, [129:98] resync_count
    output logic [135:0] m_tdata,
    // [2:0] ev_type, [4:3] out_slot
    output logic [4:0]   m_tuser,
    output logic         m_tlast
);

    localparam int PTR_W   = $clog2(RING_DEPTH);
    localparam int SLOT_AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;
    localparam logic [1:0] ST_WB   = 2'd3;

    logic [1:0]       state_reg, state_next;
    cmd_t             cmd_reg;
    rec_t             new_rec_reg;

    logic             s_acc;
    logic             slot_ok;
    rec_t             rec_q;
    logic [PTR_W-1:0] ptr_q;
    plan_t            plan;

    logic             rec_we;
    rec_t             rec_wdata;
    logic [PTR_W-1:0] ptr_wdata;
    logic [SLOT_AW-1:0] wr_addr;

    logic             em_start;
    logic             em_done;
    logic [PTR_W-1:0] em_ptr;
    ev_t              ev;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign slot_ok  = (32'(cmd_reg.slot) < 32'(NUM_SLOTS));
    assign wr_addr  = SLOT_AW'(cmd_reg.slot);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_acc) state_next = ST_EVAL;
            ST_EVAL: state_next = plan.run ? ST_EMIT : ST_IDLE;
            ST_EMIT: if (em_done) state_next = ST_WB;
            ST_WB:   state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            cmd_reg.func       <= s_tuser[2:0];
            cmd_reg.slot       <= s_tuser[4:3];
            cmd_reg.buttons    <= s_tdata[9:0];
            cmd_reg.left_x     <= s_tdata[26:10];
            cmd_reg.left_y     <= s_tdata[43:27];
            cmd_reg.right_x    <= s_tdata[60:44];
            cmd_reg.right_y    <= s_tdata[77:61];
            cmd_reg.trig_left  <= s_tdata[87:78];
            cmd_reg.trig_right <= s_tdata[97:88];
            cmd_reg.dpad       <= s_tdata[101:98];
        end
        if (state_reg == ST_EVAL) begin
            new_rec_reg <= plan.rec;
        end
    end

    // record of the addressed slot is read at acceptance, valid in ST_EVAL
    gsde_state_mem #(
        .W         ($bits(rec_t)),
        .DEPTH     (NUM_SLOTS),
        .AW        (SLOT_AW),
        .RESET_VAL (REC_RESET)
    ) u_rec_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_acc),
        .rd_addr (SLOT_AW'(s_tuser[4:3])),
        .rd_data (rec_q),
        .wr_en   (rec_we),
        .wr_addr (wr_addr),
        .wr_data (rec_wdata)
    );

    gsde_state_mem #(
        .W         (PTR_W),
        .DEPTH     (NUM_SLOTS),
        .AW        (SLOT_AW),
        .RESET_VAL ('0)
    ) u_ptr_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_acc),
        .rd_addr (SLOT_AW'(s_tuser[4:3])),
        .rd_data (ptr_q),
        .wr_en   (rec_we),
        .wr_addr (wr_addr),
        .wr_data (ptr_wdata)
    );

    gsde_delta u_delta (
        .cmd     (cmd_reg),
        .slot_ok (slot_ok),
        .rec     (rec_q),
        .plan    (plan)
    );

    // deactivate writes at once; a run writes after its sync word
    assign rec_we    = ((state_reg == ST_EVAL) && plan.dea) || (state_reg == ST_WB);
    assign rec_wdata = (state_reg == ST_WB) ? new_rec_reg : plan.rec;
    assign ptr_wdata = (state_reg == ST_WB) ? em_ptr : '0;
    assign em_start  = (state_reg == ST_EVAL) && plan.run;

    gsde_emitter #(
        .RING_DEPTH (RING_DEPTH),
        .PTR_W      (PTR_W)
    ) u_emitter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (em_start),
        .run       (plan.info),
        .ptr_start (ptr_q),
        .done      (em_done),
        .ptr_final (em_ptr),
        .ev_valid  (m_tvalid),
        .ev_ready  (m_tready),
        .ev        (ev)
    );

    assign m_tdata = {6'b0, ev.resync, ev.generation, ev.seq, ev.ring, ev.value, ev.code};
    assign m_tuser = {ev.slot, ev.etype};
    assign m_tlast = ev.last;

endmodule

// ----- design/gsde_checker.sv -----
// Port-level checks for the gamepad delta event encoder, bound to the top level.
module gsde_checker import gsde_pkg::*; (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [135:0] m_tdata,
    input logic [4:0]   m_tuser,
    input logic         m_tlast
);

    // a stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output word changed while stalled");

    // the closing word is a sync report with zero code and value
    a_last_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[2:0] == EV_SYN && m_tdata[25:0] == 26'd0)
        else $error("last word is not a sync report");

    // scan words carry the scan code
    a_scan_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2:0] == EV_MSC |-> m_tdata[9:0] == SCAN_EV_CODE && !m_tlast)
        else $error("bad scan word");

    // seqlock in force during a run is odd
    a_seq_odd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[34])
        else $error("even seqlock on output word");

endmodule

bind gamepad_state_delta_event_encoder gsde_checker u_gsde_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
